// ===== src/calrec_pkg.sv =====
// ----------------------------------------------------------------------------
// calrec_pkg
// Shared constants, types and the byte-wide CRC-32 update of the calibration
// record checker.
// ----------------------------------------------------------------------------
package calrec_pkg;

  localparam int unsigned CntW   = 5;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CntW-1:0] RecLen   = 5'd20;
  localparam logic [CntW-1:0] CountMax = 5'd31;

  localparam logic [31:0] CrcPoly       = 32'hEDB88320;
  localparam logic [31:0] CrcSeed       = 32'hFFFFFFFF;
  localparam logic [31:0] MagicReset    = 32'h314C4143;
  localparam logic [15:0] SchemaReset   = 16'd1;
  localparam logic [31:0] DefaultGain   = 32'h3F800000;
  localparam logic [31:0] DefaultOffset = 32'h00000000;
  localparam logic [15:0] RecLenWord    = 16'd20;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgMagic  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSchema = 2'd1;

  // verdict codes
  localparam logic [2:0] StValid    = 3'd0;
  localparam logic [2:0] StLength   = 3'd1;
  localparam logic [2:0] StMagic    = 3'd2;
  localparam logic [2:0] StSchema   = 3'd3;
  localparam logic [2:0] StSize     = 3'd4;
  localparam logic [2:0] StCrc      = 3'd5;
  localparam logic [2:0] StLastCode = StCrc;

  typedef struct packed {
    logic [CntW-1:0] count;
    logic [31:0]     crc;
    logic [31:0]     magic;
    logic [15:0]     schema;
    logic [15:0]     size;
    logic [31:0]     gain;
    logic [31:0]     offset;
    logic [31:0]     crc_word;
  } rec_t;

  localparam rec_t RecClear = '{
    count:    '0,
    crc:      CrcSeed,
    magic:    '0,
    schema:   '0,
    size:     '0,
    gain:     '0,
    offset:   '0,
    crc_word: '0
  };

  typedef struct packed {
    logic [2:0]  status;
    logic        from_store;
    logic [31:0] gain_bits;
    logic [31:0] offset_bits;
    logic [15:0] schema_out;
    logic [31:0] stored_crc;
  } res_t;

  // reflected crc-32, one byte, lsb first
  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = (c >> 1) ^ (CrcPoly & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

// ===== src/calrec_ifs.sv =====
// ----------------------------------------------------------------------------
// calrec channel interfaces
// Valid/ready channels for record bytes, verdicts and register writes.
// ----------------------------------------------------------------------------
interface calrec_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last;

  modport source (output valid, data_byte, last, input ready);
  modport sink   (input valid, data_byte, last, output ready);
endinterface

interface calrec_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic        from_store;
  logic [31:0] gain_bits;
  logic [31:0] offset_bits;
  logic [15:0] schema_out;
  logic [31:0] stored_crc;

  modport source (output valid, status, from_store, gain_bits, offset_bits, schema_out,
                  stored_crc, input ready);
  modport sink   (input valid, status, from_store, gain_bits, offset_bits, schema_out,
                  stored_crc, output ready);
endinterface

interface calrec_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/calibration_record_check.sv =====
// ----------------------------------------------------------------------------
// calibration_record_check
// Byte-serial calibration record validation with CRC-32 and default fallback.
// ----------------------------------------------------------------------------
// Takes one record byte per cycle, sustained, while the verdict side keeps up;
// the verdict for a record is registered: its last byte passes the input
// register, then the byte-wide crc update and the ordered checks feed the
// result register. A verdict waiting at the output only holds back the next
// last byte; plain record bytes keep flowing. Register writes take effect on
// the next byte and are always accepted.
module calibration_record_check (
  input  logic                clk_i,
  input  logic                rst_ni,
  calrec_in_if.sink           in_i,
  calrec_out_if.source        out_o,
  calrec_cfg_if.sink          cfg_i
);

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        take;
  logic        out_valid;
  logic [31:0] exp_magic_q;
  logic [15:0] exp_schema_q;

  calrec_pkg::rec_t rec;
  calrec_pkg::res_t res;

  // a last item waits only while an untaken verdict sits in the output
  assign take = in_valid_q && (!in_last_q || !out_valid || out_o.ready);
  assign in_i.ready = !in_valid_q || take;
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.data_byte;
      in_last_q <= in_i.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_magic_q  <= calrec_pkg::MagicReset;
      exp_schema_q <= calrec_pkg::SchemaReset;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        calrec_pkg::CfgMagic:  exp_magic_q  <= cfg_i.data;
        calrec_pkg::CfgSchema: exp_schema_q <= cfg_i.data[15:0];
        default: begin
        end
      endcase
    end
  end

  calrec_accum u_accum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .data_byte_i (in_byte_q),
    .last_i      (in_last_q),
    .rec_o       (rec)
  );

  calrec_verdict u_verdict (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .load_i            (take && in_last_q),
    .pop_i             (out_o.ready),
    .rec_i             (rec),
    .expected_magic_i  (exp_magic_q),
    .expected_schema_i (exp_schema_q),
    .valid_o           (out_valid),
    .res_o             (res)
  );

  assign out_o.valid       = out_valid;
  assign out_o.status      = res.status;
  assign out_o.from_store  = res.from_store;
  assign out_o.gain_bits   = res.gain_bits;
  assign out_o.offset_bits = res.offset_bits;
  assign out_o.schema_out  = res.schema_out;
  assign out_o.stored_crc  = res.stored_crc;

endmodule

// ===== src/calrec_accum.sv =====
// ----------------------------------------------------------------------------
// calrec_accum
// Record field capture, byte count and running CRC; shows the updated record.
// ----------------------------------------------------------------------------
module calrec_accum (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              take_i,
  input  logic [7:0]        data_byte_i,
  input  logic              last_i,
  output calrec_pkg::rec_t  rec_o
);

  calrec_pkg::rec_t rec_q, rec_d, upd;
  logic [calrec_pkg::CntW-1:0] idx;
  logic [7:0] fed;

  assign idx = rec_q.count;

  always_comb begin
    upd = rec_q;
    fed = data_byte_i;
    if (idx < calrec_pkg::RecLen) begin
      priority if (idx < 5'd4) begin
        upd.magic[{idx[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (idx < 5'd6) begin
        upd.schema[{idx[0], 3'b000} +: 8] = data_byte_i;
      end else if (idx < 5'd8) begin
        upd.size[{idx[0], 3'b000} +: 8] = data_byte_i;
      end else if (idx < 5'd12) begin
        upd.gain[{idx[1:0], 3'b000} +: 8] = data_byte_i;
      end else if (idx < 5'd16) begin
        upd.offset[{idx[1:0], 3'b000} +: 8] = data_byte_i;
      end else begin
        // crc bytes enter the checksum as zero
        upd.crc_word[{idx[1:0], 3'b000} +: 8] = data_byte_i;
        fed = 8'd0;
      end
      upd.crc = calrec_pkg::crc_byte(rec_q.crc, fed);
    end
    upd.count = (idx != calrec_pkg::CountMax) ? idx + 5'd1 : calrec_pkg::CountMax;
  end

  always_comb begin
    rec_d = rec_q;
    if (take_i) begin
      rec_d = last_i ? calrec_pkg::RecClear : upd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= calrec_pkg::RecClear;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = upd;

endmodule

// ===== src/calrec_verdict.sv =====
// ----------------------------------------------------------------------------
// calrec_verdict
// Ordered record checks and the registered verdict item.
// ----------------------------------------------------------------------------
module calrec_verdict (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic              pop_i,
  input  calrec_pkg::rec_t  rec_i,
  input  logic [31:0]       expected_magic_i,
  input  logic [15:0]       expected_schema_i,
  output logic              valid_o,
  output calrec_pkg::res_t  res_o
);

  logic             valid_q, valid_d;
  calrec_pkg::res_t res_q, res_d;
  logic [2:0]       status;

  always_comb begin
    priority if (rec_i.count != calrec_pkg::RecLen) begin
      status = calrec_pkg::StLength;
    end else if (rec_i.magic != expected_magic_i) begin
      status = calrec_pkg::StMagic;
    end else if (rec_i.schema != expected_schema_i) begin
      status = calrec_pkg::StSchema;
    end else if (rec_i.size != calrec_pkg::RecLenWord) begin
      status = calrec_pkg::StSize;
    end else if (rec_i.crc_word != ~rec_i.crc) begin
      status = calrec_pkg::StCrc;
    end else begin
      status = calrec_pkg::StValid;
    end
  end

  always_comb begin
    res_d.status     = status;
    res_d.stored_crc = rec_i.crc_word;
    if (status == calrec_pkg::StValid) begin
      res_d.from_store  = 1'b1;
      res_d.gain_bits   = rec_i.gain;
      res_d.offset_bits = rec_i.offset;
      res_d.schema_out  = rec_i.schema;
    end else begin
      res_d.from_store  = 1'b0;
      res_d.gain_bits   = calrec_pkg::DefaultGain;
      res_d.offset_bits = calrec_pkg::DefaultOffset;
      res_d.schema_out  = expected_schema_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (pop_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_d;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

// ===== src/calrec_checker.sv =====
// ----------------------------------------------------------------------------
// calrec_checker
// Port-level checks on the verdict channel, bound to the top level.
// ----------------------------------------------------------------------------
module calrec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [2:0]  status_i,
  input logic        from_store_i,
  input logic [31:0] gain_bits_i,
  input logic [31:0] offset_bits_i
);

  // a stalled verdict holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(status_i)
      && $stable(gain_bits_i) && $stable(offset_bits_i))
    else $error("stalled verdict changed");

  // coefficients come from the record exactly on a valid verdict
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (from_store_i == (status_i == calrec_pkg::StValid)))
    else $error("from_store disagrees with status");

  // defaults are one and zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !from_store_i |->
      gain_bits_i == calrec_pkg::DefaultGain && offset_bits_i == calrec_pkg::DefaultOffset)
    else $error("wrong default coefficients");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> status_i <= calrec_pkg::StLastCode)
    else $error("status code out of range");

endmodule

bind calibration_record_check calrec_checker u_calrec_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .from_store_i  (out_o.from_store),
  .gain_bits_i   (out_o.gain_bits),
  .offset_bits_i (out_o.offset_bits)
);
